FILE: rtl/hmdp_pkg.sv
// Package for the HID mouse descriptor parser: beat types, item codes and constants.
// Used by the front, the back and the top level; depends on nothing.
package hmdp_pkg;

   typedef struct packed {
      logic [7:0] desc_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic       status;
      logic       id_present;
      logic [7:0] report_id;
      logic [7:0] button_offset;
      logic [7:0] x_offset;
      logic [7:0] x_bytes;
      logic [7:0] y_offset;
      logic [7:0] y_bytes;
      logic [7:0] wheel_offset;
      logic [7:0] wheel_bytes;
   } rsp_beat_type;

   // One assembled short item handed from the front to the back.
   typedef struct packed {
      logic        run;
      logic [7:0]  header;
      logic [31:0] data;
      logic        last;
   } item_type;

   localparam logic [31:0] NOT_FOUND    = 32'd255;
   localparam logic [31:0] PAGE_DESKTOP = 32'h1;
   localparam logic [31:0] PAGE_BUTTON  = 32'h9;
   localparam logic [31:0] USE_MOUSE    = 32'h2;
   localparam logic [31:0] USE_X        = 32'h30;
   localparam logic [31:0] USE_Y        = 32'h31;
   localparam logic [31:0] USE_WHEEL    = 32'h38;

   localparam logic [1:0] TYPE_MAIN   = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL = 2'd1;
   localparam logic [1:0] TYPE_LOCAL  = 2'd2;

   localparam logic [3:0] TAG_INPUT      = 4'h8;
   localparam logic [3:0] TAG_COLLECTION = 4'hA;
   localparam logic [3:0] TAG_END_COLL   = 4'hC;
   localparam logic [3:0] TAG_PAGE       = 4'h0;
   localparam logic [3:0] TAG_RSIZE      = 4'h7;
   localparam logic [3:0] TAG_RID        = 4'h8;
   localparam logic [3:0] TAG_RCOUNT     = 4'h9;
   localparam logic [3:0] TAG_USAGE      = 4'h0;

endpackage

FILE: rtl/hmdp_front.sv
// Front part: assembles short items from descriptor bytes.
// Depends on hmdp_pkg.
module hmdp_front import hmdp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         beat_valid,
   input  req_beat_type beat,
   output logic         item_valid,
   output item_type     item
);

   logic [7:0]  header_ff, header_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  left_ff, left_in;
   logic [2:0]  size_w;
   logic [1:0]  idx_w;

   always_comb begin
      size_w = (beat.desc_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, beat.desc_byte[1:0]};
      header_in = header_ff;
      data_in = data_ff;
      left_in = left_ff;
      idx_w = 2'd0;
      item.run = 1'b0;
      item.header = header_ff;
      item.data = data_ff;
      item.last = beat.last_byte;
      if (left_ff == 3'd0) begin
         header_in = beat.desc_byte;
         data_in = 32'd0;
         left_in = size_w;
         item.header = beat.desc_byte;
         item.data = 32'd0;
         item.run = (size_w == 3'd0);
      end else begin
         idx_w = 2'(((header_ff[1:0] == 2'd3) ? 3'd4 : {1'b0, header_ff[1:0]}) - left_ff);
         data_in = data_ff | ({24'd0, beat.desc_byte} << {idx_w, 3'd0});
         left_in = left_ff - 3'd1;
         item.data = data_in;
         item.run = (left_in == 3'd0);
      end
      if (beat.last_byte) begin
         left_in = 3'd0;
         data_in = 32'd0;
         header_in = 8'd0;
      end
      item_valid = beat_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
         header_ff <= 8'd0;
         data_ff <= 32'd0;
      end else if (beat_valid) begin
         left_ff <= left_in;
         header_ff <= header_in;
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/hmdp_queue.sv
// Short queue of beats; used between the front and the back and at the result side.
// Depends on nothing.
module hmdp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH_LOG2 = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ff, rd_ff;
   logic [DEPTH_LOG2:0] cnt_ff;
   logic                do_push, do_pop;

   assign full = (cnt_ff == (DEPTH_LOG2+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (DEPTH_LOG2+1)'(do_push) - (DEPTH_LOG2+1)'(do_pop);
      end
   end

endmodule

FILE: rtl/hmdp_back.sv
// Back part: executes assembled items and tracks the mouse report layout.
// Depends on hmdp_pkg.
module hmdp_back import hmdp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  item_type     item,
   output logic         rsp_valid,
   output rsp_beat_type rsp
);

   logic [7:0]  nest_ff, nest_in;
   logic        mouse_ff, mouse_in;
   logic [31:0] boff_ff, boff_in;
   logic [31:0] page_ff, page_in;
   logic [31:0] ucnt_ff, ucnt_in;
   logic [31:0] xs_ff, xs_in, ys_ff, ys_in, ws_ff, ws_in;
   logic [31:0] fcnt_ff, fcnt_in, fbits_ff, fbits_in;
   logic        abort_ff, abort_in;
   rsp_beat_type lay_ff, lay_in;
   logic [1:0]  typ_w;
   logic [3:0]  tag_w;
   logic [31:0] xp_w, yp_w, wp_w, adv_w;
   logic        xok_w, yok_w, wok_w, wide_ok_w, desk_w;

   function automatic logic place_ok(input logic [31:0] slot, input logic [7:0] off,
                                     input logic [31:0] pos, input logic wok);
      place_ok = (slot == NOT_FOUND) || (off != 8'd255) || ((pos[2:0] == 3'd0) && wok);
   endfunction

   always_comb begin
      typ_w = item.header[3:2];
      tag_w = item.header[7:4];
      xp_w = boff_ff + xs_ff * fbits_ff;
      yp_w = boff_ff + ys_ff * fbits_ff;
      wp_w = boff_ff + ws_ff * fbits_ff;
      adv_w = fcnt_ff * fbits_ff;
      wide_ok_w = (fbits_ff == 32'd8) || (fbits_ff == 32'd16);
      xok_w = place_ok(xs_ff, lay_ff.x_offset, xp_w, wide_ok_w);
      yok_w = place_ok(ys_ff, lay_ff.y_offset, yp_w, wide_ok_w);
      wok_w = place_ok(ws_ff, lay_ff.wheel_offset, wp_w, wide_ok_w);
      desk_w = (page_ff == PAGE_DESKTOP);
      nest_in = nest_ff; mouse_in = mouse_ff; boff_in = boff_ff; page_in = page_ff;
      ucnt_in = ucnt_ff; xs_in = xs_ff; ys_in = ys_ff; ws_in = ws_ff;
      fcnt_in = fcnt_ff; fbits_in = fbits_ff; abort_in = abort_ff; lay_in = lay_ff;
      if (item.run && !abort_ff) begin
         case (typ_w)
            TYPE_MAIN: begin
               if (tag_w == TAG_COLLECTION) begin
                  nest_in = nest_ff + 8'd1;
                  ucnt_in = 32'd0;
               end else if (tag_w == TAG_END_COLL) begin
                  nest_in = nest_ff - 8'd1;
                  ucnt_in = 32'd0;
               end else if (tag_w == TAG_INPUT && mouse_ff) begin
                  if (!(xok_w && yok_w && wok_w)) begin
                     abort_in = 1'b1;
                     if (xok_w && xs_ff != NOT_FOUND && lay_ff.x_offset == 8'd255) begin
                        lay_in.x_offset = xp_w[10:3];
                        lay_in.x_bytes = fbits_ff[10:3];
                     end
                     if (xok_w && yok_w && ys_ff != NOT_FOUND
                         && lay_ff.y_offset == 8'd255) begin
                        lay_in.y_offset = yp_w[10:3];
                        lay_in.y_bytes = fbits_ff[10:3];
                     end
                  end else begin
                     if (xs_ff != NOT_FOUND && lay_ff.x_offset == 8'd255) begin
                        lay_in.x_offset = xp_w[10:3];
                        lay_in.x_bytes = fbits_ff[10:3];
                     end
                     if (ys_ff != NOT_FOUND && lay_ff.y_offset == 8'd255) begin
                        lay_in.y_offset = yp_w[10:3];
                        lay_in.y_bytes = fbits_ff[10:3];
                     end
                     if (ws_ff != NOT_FOUND && lay_ff.wheel_offset == 8'd255) begin
                        lay_in.wheel_offset = wp_w[10:3];
                        lay_in.wheel_bytes = fbits_ff[10:3];
                     end
                     boff_in = boff_ff + adv_w;
                     ucnt_in = 32'd0;
                     xs_in = NOT_FOUND; ys_in = NOT_FOUND; ws_in = NOT_FOUND;
                  end
               end
            end
            TYPE_GLOBAL: begin
               if (tag_w == TAG_PAGE) begin
                  page_in = item.data;
                  if (mouse_ff && lay_ff.button_offset == 8'd255
                      && item.data == PAGE_BUTTON) begin
                     if (boff_ff[2:0] != 3'd0) begin
                        abort_in = 1'b1;
                     end else begin
                        lay_in.button_offset = boff_ff[10:3];
                     end
                  end
               end else if (mouse_ff) begin
                  if (tag_w == TAG_RID) begin
                     boff_in = boff_ff + 32'd8;
                     lay_in.id_present = 1'b1;
                     lay_in.report_id = item.data[7:0];
                  end else if (tag_w == TAG_RCOUNT) begin
                     fcnt_in = item.data;
                  end else if (tag_w == TAG_RSIZE) begin
                     fbits_in = item.data;
                  end
               end
            end
            TYPE_LOCAL: begin
               if (tag_w == TAG_USAGE) begin
                  if (nest_ff == 8'd0) begin
                     mouse_in = desk_w && (item.data == USE_MOUSE);
                  end else if (mouse_ff && desk_w) begin
                     if (item.data == USE_X && xs_ff == NOT_FOUND) begin
                        xs_in = ucnt_ff;
                     end else if (item.data == USE_Y && ys_ff == NOT_FOUND) begin
                        ys_in = ucnt_ff;
                     end else if (item.data == USE_WHEEL && ws_ff == NOT_FOUND) begin
                        ws_in = ucnt_ff;
                     end
                  end
                  ucnt_in = ucnt_ff + 32'd1;
               end
            end
            default: begin
            end
         endcase
      end
      rsp = lay_in;
      rsp.status = abort_in;
      rsp_valid = item_valid && item.last;
   end

   always_ff @(posedge clock) begin
      if (reset || (item_valid && item.last)) begin
         nest_ff <= 8'd0; mouse_ff <= 1'b0; boff_ff <= 32'd0; page_ff <= 32'd0;
         ucnt_ff <= 32'd0; xs_ff <= NOT_FOUND; ys_ff <= NOT_FOUND; ws_ff <= NOT_FOUND;
         fcnt_ff <= 32'd0; fbits_ff <= 32'd0; abort_ff <= 1'b0;
         lay_ff <= '{status: 1'b0, id_present: 1'b0, report_id: 8'd0,
                     button_offset: 8'd255, x_offset: 8'd255, x_bytes: 8'd255,
                     y_offset: 8'd255, y_bytes: 8'd255, wheel_offset: 8'd255,
                     wheel_bytes: 8'd255};
      end else if (item_valid) begin
         nest_ff <= nest_in; mouse_ff <= mouse_in; boff_ff <= boff_in; page_ff <= page_in;
         ucnt_ff <= ucnt_in; xs_ff <= xs_in; ys_ff <= ys_in; ws_ff <= ws_in;
         fcnt_ff <= fcnt_in; fbits_ff <= fbits_in; abort_ff <= abort_in;
         lay_ff <= lay_in;
      end
   end

endmodule

FILE: rtl/hid_mouse_descriptor_parser_top.sv
// Top level of the HID mouse descriptor parser: front, item queue, back, result queue.
// A result passes the item queue and the result queue before it can be popped.
// Throughput: one descriptor byte per cycle while req_full is low.
// Reset is synchronous and active high; it empties both queues and clears all state.
// Depends on hmdp_pkg, hmdp_front, hmdp_queue and hmdp_back.
module hid_mouse_descriptor_parser_top import hmdp_pkg::*; #(
   parameter int QUEUE_LOG2 = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_beat_type req_data,
   output logic         req_full,
   input  logic         rsp_pop,
   output rsp_beat_type rsp_data,
   output logic         rsp_empty
);

   logic         acc_w, front_valid, iq_full, iq_empty, back_take, rsp_valid, rq_full;
   item_type     front_item, back_item;
   rsp_beat_type back_rsp;

   assign acc_w = req_push && !req_full;
   assign req_full = iq_full;
   // Items leave the queue only when a result slot is free.
   assign back_take = !iq_empty && !rq_full;

   hmdp_front u_front (
      .clock(clock), .reset(reset), .beat_valid(acc_w), .beat(req_data),
      .item_valid(front_valid), .item(front_item)
   );

   hmdp_queue #(.WIDTH($bits(item_type)), .DEPTH_LOG2(QUEUE_LOG2)) u_iq (
      .clock(clock), .reset(reset), .push(front_valid), .push_data(front_item),
      .full(iq_full), .pop(back_take), .pop_data(back_item), .empty(iq_empty)
   );

   hmdp_back u_back (
      .clock(clock), .reset(reset), .item_valid(back_take), .item(back_item),
      .rsp_valid(rsp_valid), .rsp(back_rsp)
   );

   hmdp_queue #(.WIDTH($bits(rsp_beat_type)), .DEPTH_LOG2(QUEUE_LOG2)) u_rq (
      .clock(clock), .reset(reset), .push(rsp_valid), .push_data(back_rsp),
      .full(rq_full), .pop(rsp_pop), .pop_data(rsp_data), .empty(rsp_empty)
   );

`ifndef NO_ASSERTIONS
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rq_full) else $error("result queue overflow");
   a_take_only_with_item: assert property (@(posedge clock) disable iff (reset)
      back_take |-> !iq_empty) else $error("item taken from empty queue");
   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      (back_take && !back_item.last && back_rsp.status) |=> back_rsp.status)
      else $error("abort flag lost within a descriptor");
`endif

endmodule
